// ----- design/pge_pkg.sv -----
// Shared types and constants for the polynomial gradient evaluator.
package pge_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned WIDE_W  = 48;
   localparam int unsigned NIB_W   = 4;
   localparam int unsigned NVAR    = 4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [5:0]         term_index;
      logic signed [31:0] term_coefficient;
      logic [15:0]        term_exponents;
      logic signed [31:0] coord_0;
      logic signed [31:0] coord_1;
      logic signed [31:0] coord_2;
      logic signed [31:0] coord_3;
   } req_type;

   typedef struct packed {
      logic signed [31:0] grad_0;
      logic signed [31:0] grad_1;
      logic signed [31:0] grad_2;
      logic signed [31:0] grad_3;
      logic               saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_MUL,
      ST_WAIT,
      ST_ACC,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

// ----- design/pge_mul.sv -----
// Shared multiplier: wide signed value times a Q16.16 coordinate or an integer, clipped.
module pge_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  go,
   input  logic                                  int_mode,
   input  logic signed [pge_pkg::WIDE_W-1:0]     a,
   input  logic signed [pge_pkg::COORD_W-1:0]    x,
   output logic                                  done,
   output logic signed [pge_pkg::WIDE_W-1:0]     y,
   output logic                                  clip
);
   // operands captured on go, then low half, full sum, result in step 3
   logic [1:0]  step_ff;
   logic        neg_ff;
   logic        int_ff;
   logic [47:0] ma_ff;
   logic [31:0] mx_ff;
   logic [55:0] lo_ff;
   logic [79:0] full_ff;
   logic [55:0] hi_prod;
   logic [79:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
      end else if (go) begin
         step_ff <= 2'd1;
      end else if (step_ff != 2'd0) begin
         step_ff <= step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         neg_ff <= a[47] ^ x[31];
         int_ff <= int_mode;
         ma_ff  <= a[47] ? 48'(-a) : 48'(a);
         mx_ff  <= x[31] ? 32'(-x) : 32'(x);
      end
      lo_ff   <= 56'(ma_ff[23:0]) * 56'(mx_ff);
      full_ff <= 80'(lo_ff) + (80'(hi_prod) << 24);
   end

   always_comb begin
      hi_prod = 56'(ma_ff[47:24]) * 56'(mx_ff);
      done    = (step_ff == 2'd3);
      mag     = int_ff ? full_ff : (full_ff >> 16);
      clip    = 1'b0;
      if (neg_ff) begin
         if (mag > 80'h8000_0000_0000) begin
            clip = 1'b1;
            y    = 48'sh8000_0000_0000;
         end else begin
            y = 48'(-mag);
         end
      end else begin
         if (mag > 80'h7FFF_FFFF_FFFF) begin
            clip = 1'b1;
            y    = 48'sh7FFF_FFFF_FFFF;
         end else begin
            y = 48'(mag);
         end
      end
   end
endmodule

// ----- design/polynomial_gradient_eval.sv -----
// Top level of the polynomial gradient evaluator.
// A request transfer is taken at a rising edge where start is high and busy is
// low. The receiver cannot stall: each result is shown for exactly one cycle
// with rsp_valid and is taken at the edge that ends it. A load writes one term
// into the coefficient and exponent memories in its transfer cycle, gives no
// result and leaves busy low, so loads can follow back to back. An evaluate
// raises busy and walks variables j, then terms k, then exponent steps through
// one shared multiplier; each product takes one issue state and three pipeline
// steps. Per variable, FETCH and NEXT do the end-of-table check and the final
// clip; a term whose exponent of j is zero passes only FETCH and SCALE, and
// every other term passes FETCH, SCALE, one product per unit of its total
// degree over the DIMS variables and ACC. The DONE state closes the walk; busy
// drops and the result is shown in the same cycle. Reading a term slot never
// loaded is undefined.
module polynomial_gradient_eval #(
   parameter int unsigned DIMS         = 4,
   parameter int unsigned MAX_TERMS    = 64,
   parameter int unsigned MAX_EXPONENT = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pge_pkg::req_type  req_data,
   output logic              rsp_valid,
   output pge_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_data
);
   localparam int unsigned IDX_W = $clog2(MAX_TERMS);

   // term memories
   logic signed [31:0] coef_mem [MAX_TERMS];
   logic [15:0]        expo_mem [MAX_TERMS];
   logic signed [31:0] coef_rd_ff;
   logic [15:0]        expo_rd_ff;

   logic [6:0]  term_count_ff;
   logic [8:0]  used;

   pge_pkg::state_type state_ff, state_in;
   logic [8:0]  k_ff, k_in;
   logic [1:0]  j_ff, j_in;
   logic [1:0]  m_ff, m_in;
   logic [3:0]  t_ff, t_in;
   logic signed [47:0] term_ff, term_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [31:0] x_ff [pge_pkg::NVAR];
   logic signed [31:0] g_ff [pge_pkg::NVAR];
   logic signed [31:0] g_val;
   logic        g_we;
   logic        sat_ff, sat_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mul_go;
   logic        mul_int;
   logic signed [47:0] mul_a;
   logic signed [31:0] mul_x;
   logic        mul_done;
   logic signed [47:0] mul_y;
   logic        mul_clip;

   logic [3:0]  ej;
   logic [3:0]  em;
   logic signed [48:0] add_s;
   logic signed [47:0] add_c;
   logic        add_clip;
   logic [8:0]  k_rd;

   function automatic logic [3:0] exp_of(logic [15:0] p, logic [1:0] idx);
      logic [3:0] e;
      e = p[idx*pge_pkg::NIB_W +: pge_pkg::NIB_W];
      return (e > 4'(MAX_EXPONENT)) ? 4'(MAX_EXPONENT) : e;
   endfunction

   assign used      = (9'(term_count_ff) > 9'(MAX_TERMS)) ? 9'(MAX_TERMS) : 9'(term_count_ff);
   assign busy      = (state_ff != pge_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{grad_0: g_ff[0], grad_1: g_ff[1], grad_2: g_ff[2],
                        grad_3: g_ff[3], saturated: sat_ff};

   pge_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .go       (mul_go),
      .int_mode (mul_int),
      .a        (mul_a),
      .x        (mul_x),
      .done     (mul_done),
      .y        (mul_y),
      .clip     (mul_clip)
   );

   // operand select: coefficient times e_j in the scale step, else term times x_m
   always_comb begin
      ej = exp_of(expo_rd_ff, j_ff);
      em = exp_of(expo_rd_ff, m_ff);
      if (m_ff == j_ff) em = em - 4'd1;
      mul_int = (state_ff == pge_pkg::ST_SCALE);
      mul_a   = mul_int ? {{16{coef_rd_ff[31]}}, coef_rd_ff} : term_ff;
      mul_x   = mul_int ? 32'(ej) : x_ff[m_ff];
      add_s   = 49'(sum_ff) + 49'(term_ff);
      add_clip = 1'b0;
      add_c   = add_s[47:0];
      if (add_s > 49'sh7FFF_FFFF_FFFF) begin
         add_clip = 1'b1; add_c = 48'sh7FFF_FFFF_FFFF;
      end else if (add_s < -49'sh8000_0000_0000) begin
         add_clip = 1'b1; add_c = 48'sh8000_0000_0000;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in = k_ff; j_in = j_ff; m_in = m_ff; t_in = t_ff;
      term_in = term_ff; sum_in = sum_ff; sat_in = sat_ff;
      rsp_valid_in = 1'b0;
      g_we = 1'b0; g_val = '0;
      mul_go = 1'b0;
      k_rd = k_ff;
      unique case (state_ff)
         pge_pkg::ST_IDLE: begin
            if (start && req_data.opcode == pge_pkg::OP_EVAL) begin
               j_in = '0; k_in = '0; sum_in = '0; sat_in = 1'b0;
               state_in = pge_pkg::ST_FETCH;
            end
         end
         pge_pkg::ST_FETCH: begin
            // memory read issued for k_ff; data valid next cycle
            if (k_ff >= used) state_in = pge_pkg::ST_NEXT;
            else state_in = pge_pkg::ST_SCALE;
         end
         pge_pkg::ST_SCALE: begin
            if (ej == 4'd0) begin
               k_in = k_ff + 9'd1;
               state_in = pge_pkg::ST_FETCH;
            end else begin
               mul_go = 1'b1;
               m_in = '0; t_in = '0;
               state_in = pge_pkg::ST_WAIT;
            end
         end
         pge_pkg::ST_MUL: begin
            if (t_ff < em) begin
               mul_go = 1'b1;
               t_in = t_ff + 4'd1;
               state_in = pge_pkg::ST_WAIT;
            end else begin
               t_in = '0;
               if (32'(m_ff) == DIMS - 1) state_in = pge_pkg::ST_ACC;
               else m_in = m_ff + 2'd1;
            end
         end
         pge_pkg::ST_WAIT: begin
            if (mul_done) begin
               term_in = mul_y;
               if (mul_clip) sat_in = 1'b1;
               state_in = pge_pkg::ST_MUL;
            end
         end
         pge_pkg::ST_ACC: begin
            sum_in = add_c;
            if (add_clip) sat_in = 1'b1;
            k_in = k_ff + 9'd1;
            state_in = pge_pkg::ST_FETCH;
         end
         pge_pkg::ST_NEXT: begin
            g_we = 1'b1;
            if (sum_ff > 48'sh0000_7FFF_FFFF) begin
               g_val = 32'sh7FFF_FFFF; sat_in = 1'b1;
            end else if (sum_ff < -48'sh0000_8000_0000) begin
               g_val = 32'sh8000_0000; sat_in = 1'b1;
            end else begin
               g_val = sum_ff[31:0];
            end
            sum_in = '0; k_in = '0;
            if (32'(j_ff) == DIMS - 1) state_in = pge_pkg::ST_DONE;
            else begin
               j_in = j_ff + 2'd1;
               state_in = pge_pkg::ST_FETCH;
            end
         end
         pge_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = pge_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers and the term count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pge_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         term_count_ff <= 7'd10;
         sat_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_ff       <= sat_in;
         if (csr_valid) term_count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; j_ff <= j_in; m_ff <= m_in; t_ff <= t_in;
      sum_ff <= sum_in;
      term_ff <= term_in;
      coef_rd_ff <= coef_mem[k_rd[IDX_W-1:0]];
      expo_rd_ff <= expo_mem[k_rd[IDX_W-1:0]];
      if (start && !busy && req_data.opcode == pge_pkg::OP_LOAD
          && 32'(req_data.term_index) < MAX_TERMS) begin
         coef_mem[IDX_W'(req_data.term_index)] <= req_data.term_coefficient;
         expo_mem[IDX_W'(req_data.term_index)] <= req_data.term_exponents;
      end
      if (start && !busy && req_data.opcode == pge_pkg::OP_EVAL) begin
         x_ff[0] <= req_data.coord_0; x_ff[1] <= req_data.coord_1;
         x_ff[2] <= req_data.coord_2; x_ff[3] <= req_data.coord_3;
      end
      if (start && !busy && req_data.opcode == pge_pkg::OP_EVAL) begin
         for (int i = 0; i < pge_pkg::NVAR; i++) g_ff[i] <= '0;
      end else if (g_we && 32'(j_ff) < DIMS) begin
         g_ff[j_ff] <= g_val;
      end
   end
endmodule
